// ----- hdl/dqpi_pkg.sv -----
// Shared types, constants and the control program of the dq current PI controller.
`default_nettype none

package dqpi_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int WORD_W = 32;
   localparam int PROD_W = 64;
   localparam int STEP_W = 4;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [PROD_W-1:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [PROD_W-1:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PROP_GAIN     = 3'd0,
      REG_INTEGRAL_GAIN = 3'd1,
      REG_SAMPLE_PERIOD = 3'd2,
      REG_ACTIVE_RES    = 3'd3,
      REG_LEAK_IND      = 3'd4,
      REG_VOLT_UPPER    = 3'd5,
      REG_VOLT_LOWER    = 3'd6
   } reg_idx_type;

   typedef enum logic [2:0] {
      MA_LEAK,
      MA_PROP,
      MA_SAMPLE,
      MA_RES,
      MA_IGAIN,
      MA_COUP
   } mul_a_type;

   typedef enum logic [2:0] {
      MB_SPEED,
      MB_ERR,
      MB_OWN,
      MB_INTEG,
      MB_OTHER
   } mul_b_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ERR,
      OP_COUP,
      OP_ACC_LOAD,
      OP_INTEG,
      OP_ACC_SUB,
      OP_ACC_ADD,
      OP_ACC_CROSS,
      OP_FINISH
   } alu_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_WAIT_REQ,
      SEQ_WAIT_RSP
   } seq_type;

   typedef struct packed {
      mul_a_type  mul_a;
      mul_b_type  mul_b;
      alu_op_type op;
      seq_type    seq;
   } ctrl_type;

   localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_INTEG  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_FINISH = 4'd8;

   // Each step applies op (for most ops to the product of the previous step) and issues a new multiply.
   function automatic ctrl_type program_word(input logic [STEP_W-1:0] step);
      ctrl_type w;
      w = '{mul_a: MA_LEAK, mul_b: MB_SPEED, op: OP_NONE, seq: SEQ_WAIT_REQ};
      unique case (step)
         4'd0: w = '{mul_a: MA_LEAK,   mul_b: MB_SPEED, op: OP_NONE,      seq: SEQ_WAIT_REQ};
         4'd1: w = '{mul_a: MA_LEAK,   mul_b: MB_SPEED, op: OP_ERR,       seq: SEQ_NEXT};
         4'd2: w = '{mul_a: MA_PROP,   mul_b: MB_ERR,   op: OP_COUP,      seq: SEQ_NEXT};
         4'd3: w = '{mul_a: MA_SAMPLE, mul_b: MB_ERR,   op: OP_ACC_LOAD,  seq: SEQ_NEXT};
         4'd4: w = '{mul_a: MA_RES,    mul_b: MB_OWN,   op: OP_INTEG,     seq: SEQ_NEXT};
         4'd5: w = '{mul_a: MA_IGAIN,  mul_b: MB_INTEG, op: OP_ACC_SUB,   seq: SEQ_NEXT};
         4'd6: w = '{mul_a: MA_COUP,   mul_b: MB_OTHER, op: OP_ACC_ADD,   seq: SEQ_NEXT};
         4'd7: w = '{mul_a: MA_COUP,   mul_b: MB_OTHER, op: OP_ACC_CROSS, seq: SEQ_NEXT};
         4'd8: w = '{mul_a: MA_COUP,   mul_b: MB_OTHER, op: OP_FINISH,    seq: SEQ_WAIT_RSP};
         default: w = '{mul_a: MA_LEAK, mul_b: MB_SPEED, op: OP_NONE, seq: SEQ_WAIT_REQ};
      endcase
      return w;
   endfunction

   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [WORD_W-1:0] r;
      if (v > S32_MAX) begin
         r = S32_MAX[WORD_W-1:0];
      end else if (v < S32_MIN) begin
         r = S32_MIN[WORD_W-1:0];
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/dq_current_pi_decoupled.sv -----
// Microcoded dq-axis PI current controller with active resistance and decoupling.
// Steps 1 to 8 of the nine-step program run from request accept to rsp_tvalid, one
// per cycle but step 8 waits for a free output register, through one shared 32x32
// multiplier with a registered product. A new request is taken only in the idle step 0.
// A new request is taken while the previous result waits in the output register.
// Reset (synchronous, active high) clears the CSRs, integrator, windup flag and sequencer.
`default_nettype none

module dq_current_pi_decoupled
   import dqpi_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request: tdata = current_target[31:0], current_own[63:32],
   //          current_other[95:64], elec_speed[127:96]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [4*WORD_W-1:0]   req_tdata,
   input  wire logic [0:0]            req_tuser,    // axis_is_d[0]
   // response: tdata = voltage_cmd[31:0]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [WORD_W-1:0]          rsp_tdata,
   output logic [0:0]                 rsp_tuser,    // clamped[0]
   // register writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [WORD_W-1:0]     csr_data
);

   // configuration
   logic signed [WORD_W-1:0] prop_gain_ff, integral_gain_ff, active_res_ff, leak_ind_ff;
   logic signed [WORD_W-1:0] volt_upper_ff, volt_lower_ff;
   logic [WORD_W-2:0]        sample_period_ff;

   // latched request
   logic signed [WORD_W-1:0] target_ff, own_ff, other_ff, speed_ff;
   logic                     is_d_ff;

   // datapath
   logic signed [WORD_W-1:0] err_ff, err_in;
   logic signed [WORD_W-1:0] coup_ff;
   logic signed [WORD_W-1:0] integ_ff, integ_in;
   logic                     windup_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_sh;
   logic signed [WORD_W-1:0] mul_a, mul_b;
   logic signed [WORD_W:0]   diff;

   // sequencer and output
   logic [STEP_W-1:0]        step_ff, step_in;
   ctrl_type                 ctrl;
   logic                     accept_req, load_rsp;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]        rsp_data_ff;
   logic                     rsp_clamp_ff;
   logic signed [PROD_W-1:0] upper_ext, lower_ext;
   logic signed [WORD_W-1:0] vout;
   logic                     hit;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= '0;
         integral_gain_ff <= '0;
         sample_period_ff <= '0;
         active_res_ff    <= '0;
         leak_ind_ff      <= '0;
         volt_upper_ff    <= '0;
         volt_lower_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PROP_GAIN:     prop_gain_ff     <= csr_data;
            REG_INTEGRAL_GAIN: integral_gain_ff <= csr_data;
            REG_SAMPLE_PERIOD: sample_period_ff <= csr_data[WORD_W-2:0];
            REG_ACTIVE_RES:    active_res_ff    <= csr_data;
            REG_LEAK_IND:      leak_ind_ff      <= csr_data;
            REG_VOLT_UPPER:    volt_upper_ff    <= csr_data;
            REG_VOLT_LOWER:    volt_lower_ff    <= csr_data;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      ctrl       = program_word(step_ff);
      req_tready = (ctrl.seq == SEQ_WAIT_REQ);
      accept_req = req_tvalid && req_tready;
      load_rsp   = (ctrl.seq == SEQ_WAIT_RSP) && (!rsp_valid_ff || rsp_tready);
   end

   always_comb begin
      step_in = step_ff;
      unique case (ctrl.seq)
         SEQ_WAIT_REQ: if (accept_req) step_in = step_ff + 1'b1;
         SEQ_NEXT:     step_in = step_ff + 1'b1;
         SEQ_WAIT_RSP: if (load_rsp) step_in = STEP_IDLE;
         default:      step_in = STEP_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      case (ctrl.mul_a)
         MA_LEAK:   mul_a = leak_ind_ff;
         MA_PROP:   mul_a = prop_gain_ff;
         MA_SAMPLE: mul_a = $signed({1'b0, sample_period_ff});
         MA_RES:    mul_a = active_res_ff;
         MA_IGAIN:  mul_a = integral_gain_ff;
         MA_COUP:   mul_a = coup_ff;
         default:   mul_a = leak_ind_ff;
      endcase
      case (ctrl.mul_b)
         MB_SPEED: mul_b = speed_ff;
         MB_ERR:   mul_b = err_ff;
         MB_OWN:   mul_b = own_ff;
         MB_INTEG: mul_b = integ_ff;
         MB_OTHER: mul_b = other_ff;
         default:  mul_b = speed_ff;
      endcase
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      // floor of product over 2^FRAC_BITS
      prod_sh   = prod_ff >>> FRAC_BITS;
      diff      = {target_ff[WORD_W-1], target_ff} - {own_ff[WORD_W-1], own_ff};
      upper_ext = PROD_W'(volt_upper_ff);
      lower_ext = PROD_W'(volt_lower_ff);

      err_in = err_ff;
      if (diff[WORD_W] != diff[WORD_W-1]) begin
         err_in = diff[WORD_W] ? S32_MIN[WORD_W-1:0] : S32_MAX[WORD_W-1:0];
      end else begin
         err_in = diff[WORD_W-1:0];
      end

      integ_in = integ_ff;
      if (!windup_ff) begin
         integ_in = sat32(PROD_W'(integ_ff) + prod_sh);
      end

      // d axis: subtract the cross term, q axis: add it
      case (ctrl.op)
         OP_ACC_LOAD:  acc_in = prod_sh;
         OP_ACC_SUB:   acc_in = acc_ff - prod_sh;
         OP_ACC_ADD:   acc_in = acc_ff + prod_sh;
         OP_ACC_CROSS: acc_in = is_d_ff ? acc_ff - prod_sh : acc_ff + prod_sh;
         default:      acc_in = acc_ff;
      endcase

      // upper limit is tested first when the limits cross
      if (acc_ff > upper_ext) begin
         vout = volt_upper_ff;
         hit  = 1'b1;
      end else if (acc_ff < lower_ext) begin
         vout = volt_lower_ff;
         hit  = 1'b1;
      end else begin
         vout = acc_ff[WORD_W-1:0];
         hit  = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_req) begin
         target_ff <= req_tdata[WORD_W-1:0];
         own_ff    <= req_tdata[2*WORD_W-1:WORD_W];
         other_ff  <= req_tdata[3*WORD_W-1:2*WORD_W];
         speed_ff  <= req_tdata[4*WORD_W-1:3*WORD_W];
         is_d_ff   <= req_tuser[0];
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (ctrl.op == OP_ERR) begin
         err_ff <= err_in;
      end
      if (ctrl.op == OP_COUP) begin
         coup_ff <= sat32(prod_sh);
      end
      if (load_rsp) begin
         rsp_data_ff  <= vout;
         rsp_clamp_ff <= hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         integ_ff     <= '0;
         windup_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.op == OP_INTEG) begin
            integ_ff <= integ_in;
         end
         if (load_rsp) begin
            windup_ff <= hit;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_clamp_ff;

   // ---------------------------------------------------------------- checks
   a_windup_only_at_finish: assert property (@(posedge clock) disable iff (reset)
      (step_ff != STEP_FINISH) |=> $stable(windup_ff))
      else $error("windup flag changed outside the finish step");

   a_integ_frozen: assert property (@(posedge clock) disable iff (reset)
      (windup_ff && step_ff == STEP_INTEG) |=> $stable(integ_ff))
      else $error("integrator moved while windup hold was set");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_ff == STEP_FINISH))
      else $error("response raised outside the finish step");

endmodule

`default_nettype wire

// ----- dv/tb_dq_current_pi_decoupled.sv -----
// Self-checking testbench for the dq current PI controller with decoupling.
`timescale 1ns / 100ps

module tb_dq_current_pi_decoupled;
   import dqpi_pkg::*;

   localparam int FRAC = FRAC_BITS_DEFAULT;
   localparam int RESET_CYCLES = 11;
   localparam int SETTLE_CYCLES = 20;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_AFTER = 120;
   localparam int HOLD_CYCLES = 300;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_ITEMS = 72;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   localparam logic signed [WORD_W-1:0] W_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] W_MIN = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] ONE = 32'sh0001_0000;

   typedef struct {
      logic signed [WORD_W-1:0] target;
      logic signed [WORD_W-1:0] own;
      logic signed [WORD_W-1:0] other;
      logic signed [WORD_W-1:0] speed;
      logic                     is_d;
   } sample_type;

   typedef struct {
      logic [WORD_W-1:0] volt;
      logic              clamped;
   } volt_type;

   typedef struct {
      logic signed [WORD_W-1:0] prop_k;
      logic signed [WORD_W-1:0] integ_k;
      logic [WORD_W-2:0]        period;
      logic signed [WORD_W-1:0] res_k;
      logic signed [WORD_W-1:0] leak_k;
      logic signed [WORD_W-1:0] v_hi;
      logic signed [WORD_W-1:0] v_lo;
   } gains_type;

   typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [4*WORD_W-1:0]   req_tdata = '0;   // current_target, current_own, current_other, elec_speed
   logic [0:0]            req_tuser = '0;   // axis_is_d
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [WORD_W-1:0]     rsp_tdata;        // voltage_cmd
   logic [0:0]            rsp_tuser;        // clamped
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [WORD_W-1:0]     csr_data = '0;

   // controller image kept by the testbench
   gains_type cfg = '{prop_k: 0, integ_k: 0, period: 0, res_k: 0, leak_k: 0, v_hi: 0, v_lo: 0};
   longint integ_acc = 0;
   bit     windup = 1'b0;

   sample_type sample_backlog[$];
   volt_type   volt_expected[$];
   sample_type in_flight;
   int      burst_left = 1;
   int      gap_left = 0;
   int      mismatches = 0;
   int      rsp_count = 0;
   int      quiet_cycles = 0;

   ready_mode_type ready_mode = RDY_ALWAYS;
   int          mode_cycles = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          seen_rsp = 0;
   int          rdy_phase = 0;

   dq_current_pi_decoupled i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   function automatic longint clip_s32(input longint v);
      if (v > longint'(W_MAX)) return longint'(W_MAX);
      if (v < longint'(W_MIN)) return longint'(W_MIN);
      return v;
   endfunction

   // exact product, floored back to the fixed-point scale
   function automatic longint fx_mul(input longint a, input longint b);
      longint p;
      p = a * b;
      return p >>> FRAC;
   endfunction

   function automatic volt_type step_current_loop(input sample_type s);
      longint   err, prop, integ, coup, cross_term, comp, v;
      volt_type r;
      err = clip_s32(longint'(s.target) - longint'(s.own));
      prop = fx_mul(longint'(cfg.prop_k), err);
      integ = integ_acc;
      if (!windup) integ = clip_s32(integ + fx_mul(longint'({1'b0, cfg.period}), err));
      coup = clip_s32(fx_mul(longint'(cfg.leak_k), longint'(s.speed)));
      cross_term = fx_mul(coup, longint'(s.other));
      comp = fx_mul(longint'(cfg.res_k), longint'(s.own));
      comp = s.is_d ? comp + cross_term : comp - cross_term;
      v = prop + fx_mul(longint'(cfg.integ_k), integ) - comp;
      // upper limit wins when the limits are crossed
      if (v > longint'(cfg.v_hi)) begin
         r.volt = cfg.v_hi;
         r.clamped = 1'b1;
      end else if (v < longint'(cfg.v_lo)) begin
         r.volt = cfg.v_lo;
         r.clamped = 1'b1;
      end else begin
         r.volt = v[WORD_W-1:0];
         r.clamped = 1'b0;
      end
      integ_acc = integ;
      windup = r.clamped;
      return r;
   endfunction

   function automatic logic signed [WORD_W-1:0] pick_value(input int span);
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 3))
               0: return W_MAX;
               1: return W_MIN;
               2: return 0;
               default: return -1;
            endcase
         end
         default: return int'($urandom_range(0, 2 * span)) - span;
      endcase
   endfunction

   function automatic sample_type pick_sample();
      sample_type s;
      s.target = pick_value(1 << 20);
      // half the time track the reference closely, as a running loop does
      if ($urandom_range(0, 1))
         s.own = s.target + int'($urandom_range(0, 1 << 13)) - (1 << 12);
      else
         s.own = pick_value(1 << 20);
      s.other = pick_value(1 << 20);
      s.speed = pick_value(1 << 22);
      s.is_d = 1'($urandom_range(0, 1));
      return s;
   endfunction

   function automatic gains_type pick_gains();
      gains_type g;
      g.prop_k = pick_value(1 << 18);
      g.integ_k = pick_value(1 << 18);
      if ($urandom_range(0, 4) == 0)
         g.period = 31'($urandom);
      else
         g.period = 31'($urandom_range(0, 1 << 14));
      g.res_k = pick_value(1 << 16);
      g.leak_k = pick_value(1 << 12);
      if ($urandom_range(0, 5) == 0) begin
         g.v_hi = $urandom;
         g.v_lo = $urandom;
      end else begin
         g.v_hi = $urandom_range(1 << 16, 1 << 24);
         g.v_lo = -int'($urandom_range(1 << 16, 1 << 24));
      end
      return g;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_PROP_GAIN:     cfg.prop_k = val;
         REG_INTEGRAL_GAIN: cfg.integ_k = val;
         REG_SAMPLE_PERIOD: cfg.period = val[WORD_W-2:0];
         REG_ACTIVE_RES:    cfg.res_k = val;
         REG_LEAK_IND:      cfg.leak_k = val;
         REG_VOLT_UPPER:    cfg.v_hi = val;
         REG_VOLT_LOWER:    cfg.v_lo = val;
         default: ;
      endcase
   endtask

   task automatic write_gains(input gains_type g);
      write_reg(REG_PROP_GAIN, g.prop_k);
      write_reg(REG_INTEGRAL_GAIN, g.integ_k);
      // top bit is outside the register, toggle it anyway
      write_reg(REG_SAMPLE_PERIOD, {1'($urandom_range(0, 1)), g.period});
      write_reg(REG_ACTIVE_RES, g.res_k);
      write_reg(REG_LEAK_IND, g.leak_k);
      write_reg(REG_VOLT_UPPER, g.v_hi);
      write_reg(REG_VOLT_LOWER, g.v_lo);
   endtask

   task automatic add_sample(input logic signed [WORD_W-1:0] target, own, other, speed,
                             input logic is_d);
      sample_type s;
      s = '{target: target, own: own, other: other, speed: speed, is_d: is_d};
      sample_backlog.push_back(s);
   endtask

   // wait until every request has been answered, then let the pipeline settle
   task automatic wait_idle();
      do @(negedge clock);
      while (sample_backlog.size() != 0 || req_tvalid || volt_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) volt_expected.push_back(step_current_loop(in_flight));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (sample_backlog.size() != 0) begin
               in_flight = sample_backlog.pop_front();
               req_tdata <= {in_flight.speed, in_flight.other, in_flight.own, in_flight.target};
               req_tuser <= in_flight.is_d;
               req_tvalid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response backpressure, with one long hold once HOLD_AFTER responses have been seen
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) seen_rsp++;
         if (!hold_done && seen_rsp >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_cycles == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_cycles = $urandom_range(16, 96);
         end
         mode_cycles--;
         rdy_phase = (rdy_phase + 1) % 3;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (ready_mode)
               RDY_ALWAYS:   rsp_tready <= 1'b1;
               RDY_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
               RDY_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
               default:      rsp_tready <= (rdy_phase == 0);
            endcase
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      volt_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (volt_expected.size() == 0) begin
            if (mismatches < 10)
               $display("response %0d unexpected: volt %h clamped %b",
                        rsp_count, rsp_tdata, rsp_tuser[0]);
            mismatches++;
         end else begin
            want = volt_expected.pop_front();
            if (rsp_tdata !== want.volt || rsp_tuser[0] !== want.clamped) begin
               if (mismatches < 10)
                  $display("response %0d: volt exp %h got %h, clamped exp %b got %b",
                           rsp_count, want.volt, rsp_tdata, want.clamped, rsp_tuser[0]);
               mismatches++;
            end
         end
         rsp_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      gains_type g;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // registers still at their reset value
      @(negedge clock);
      add_sample(ONE, 0, ONE, ONE, 1'b1);
      add_sample($urandom, $urandom, $urandom, $urandom, 1'b0);
      wait_idle();

      // nominal gains, limits at +/-100
      g = '{prop_k: 32'sh0001_8000, integ_k: 32'sh0000_8000, period: 31'h290,
            res_k: 32'sh0000_199A, leak_k: 32'sh0000_0083,
            v_hi: 32'sh0064_0000, v_lo: 32'shFF9C_0000};
      write_gains(g);
      write_reg(REG_UNUSED, $urandom);
      @(negedge clock);
      add_sample(0, 0, 0, 0, 1'b1);
      add_sample(0, 0, 0, 0, 1'b0);
      add_sample(W_MAX, W_MIN, ONE, ONE, 1'b1);
      add_sample(W_MIN, W_MAX, ONE, ONE, 1'b0);
      add_sample(W_MAX, W_MAX, W_MAX, W_MAX, 1'b1);
      add_sample(W_MIN, W_MIN, W_MIN, W_MIN, 1'b0);
      wait_idle();

      // gains, period and upper limit at their top, lower limit at its bottom: coupling and integrator saturate
      g = '{prop_k: W_MAX, integ_k: W_MAX, period: '1, res_k: W_MAX, leak_k: W_MAX,
            v_hi: W_MAX, v_lo: W_MIN};
      write_gains(g);
      @(negedge clock);
      add_sample(W_MAX, W_MIN, W_MAX, W_MAX, 1'b1);
      add_sample(W_MAX, W_MIN, W_MAX, W_MAX, 1'b0);
      add_sample(W_MIN, W_MAX, W_MIN, W_MIN, 1'b0);
      add_sample(0, 0, -1, 1, 1'b1);
      add_sample(0, 0, 0, 0, 1'b1);
      wait_idle();

      // negative extremes with a narrow window, so most samples clamp
      g = '{prop_k: W_MIN, integ_k: W_MIN, period: 0, res_k: W_MIN, leak_k: W_MIN,
            v_hi: ONE, v_lo: -ONE};
      write_gains(g);
      @(negedge clock);
      add_sample(ONE, 0, ONE, ONE, 1'b1);
      add_sample(-ONE, 0, ONE, -ONE, 1'b0);
      add_sample(0, 0, 0, 0, 1'b0);
      add_sample(W_MAX, W_MIN, W_MIN, W_MAX, 1'b1);
      wait_idle();

      // crossed limits: lower above upper
      g = '{prop_k: ONE, integ_k: 0, period: 0, res_k: 0, leak_k: 0,
            v_hi: -5 * ONE, v_lo: 5 * ONE};
      write_gains(g);
      @(negedge clock);
      add_sample(10 * ONE, 0, 0, 0, 1'b1);
      add_sample(-10 * ONE, 0, 0, 0, 1'b0);
      add_sample(0, 0, 0, 0, 1'b1);
      wait_idle();

      for (int p = 0; p < RAND_PHASES; p++) begin
         write_gains(pick_gains());
         if ($urandom_range(0, 1)) write_reg(REG_UNUSED, $urandom);
         @(negedge clock);
         for (int n = 0; n < PHASE_ITEMS; n++) sample_backlog.push_back(pick_sample());
         wait_idle();
      end

      mismatches += volt_expected.size();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- dq_current_pi_decoupled.f -----
hdl/dqpi_pkg.sv
hdl/dq_current_pi_decoupled.sv
dv/tb_dq_current_pi_decoupled.sv
